/* hdl/bbpt_pkg.sv */
// ----------------------------------------------------------------------------
// bbpt_pkg
// Shared constants and types of the ball bin persistence tracker: bin
// geometry, field widths, register indexes and reset values.
// ----------------------------------------------------------------------------
package bbpt_pkg;

  // Bin geometry
  localparam int NUM_BINS  = 10;
  localparam int BIN_WIDTH = 65;

  // Field widths
  localparam int X_W       = 10;
  localparam int RAD_W     = 9;
  localparam int CNT_W     = 5;
  localparam int BIN_OUT_W = 4;
  localparam int IDX_W     = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

  // Running upper bin bound, wide enough for NUM_BINS * BIN_WIDTH
  localparam int BOUND_MAX = NUM_BINS * BIN_WIDTH;
  localparam int BOUND_W0  = $clog2(BOUND_MAX + 1);
  localparam int BOUND_W   = (BOUND_W0 > X_W) ? BOUND_W0 : X_W;

  // Counter arithmetic
  localparam int CNT_MAX  = (1 << CNT_W) - 1;
  localparam int HIT_STEP = 2;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_RADIUS    = 2'd0,
    REG_PRESENT_THR   = 2'd1,
    REG_COUNT_CEILING = 2'd2
  } cfg_reg_t;

  localparam logic [RAD_W-1:0] MIN_RADIUS_RST    = RAD_W'(10);
  localparam logic [CNT_W-1:0] PRESENT_THR_RST   = CNT_W'(10);
  localparam logic [CNT_W-1:0] COUNT_CEILING_RST = CNT_W'(20);

  // Configuration as seen by the bin update unit
  typedef struct packed {
    logic [RAD_W-1:0] min_radius;
    logic [CNT_W-1:0] present_threshold;
    logic [CNT_W-1:0] count_ceiling;
  } bbpt_cfg_t;

  // Running best-bin search state
  typedef struct packed {
    logic             found;
    logic [CNT_W-1:0] peak;
  } bbpt_best_t;

endpackage

/* hdl/bbpt_in_if.sv */
// ----------------------------------------------------------------------------
// bbpt_in_if
// Detection channel: one word per video frame, ball centre and radius.
// ----------------------------------------------------------------------------
interface bbpt_in_if;
  import bbpt_pkg::*;

  logic             valid;
  logic             ready;
  logic [X_W-1:0]   center_x;
  logic [RAD_W-1:0] radius;

  modport source (output valid, output center_x, output radius, input ready);
  modport sink   (input valid, input center_x, input radius, output ready);
endinterface

/* hdl/bbpt_out_if.sv */
// ----------------------------------------------------------------------------
// bbpt_out_if
// Result channel: strongest qualifying bin and its counter.
// ----------------------------------------------------------------------------
interface bbpt_out_if;
  import bbpt_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 found;
  logic [BIN_OUT_W-1:0] ball_bin;
  logic [CNT_W-1:0]     peak_count;

  modport source (output valid, output found, output ball_bin, output peak_count,
                  input ready);
  modport sink   (input valid, input found, input ball_bin, input peak_count,
                  output ready);
endinterface

/* hdl/ball_bin_persistence_tracker_core.sv */
// ----------------------------------------------------------------------------
// ball_bin_persistence_tracker_core
// Per-frame column bin confidence tracker with strongest-bin report.
//
// Flow: an accepted word starts a walk over the bins in ST_WALK, and the
//   result is registered in ST_LOAD. One shared bin unit walks the counters
//   one bin per cycle; a new word is accepted only back in ST_IDLE. A result
//   word still held by the sink keeps the core in the load state.
// Reset: synchronous, clears all bin counters, restores register defaults.
// ----------------------------------------------------------------------------
module ball_bin_persistence_tracker_core (
  input  logic                            clk,
  input  logic                            rst_n,
  bbpt_in_if.sink                         in_ch,
  bbpt_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [bbpt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bbpt_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import bbpt_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_LOAD = 3'b100
  } state_t;

  state_t               state_r, state_nxt;
  bbpt_cfg_t            cfg_r;
  logic [CNT_W-1:0]     counts_r [NUM_BINS];
  logic [X_W-1:0]       x_r;
  logic [RAD_W-1:0]     radius_r;
  logic [IDX_W-1:0]     idx_r;
  logic [BOUND_W-1:0]   bound_r;
  logic                 hit_seen_r;
  bbpt_best_t           best_r;
  logic [IDX_W-1:0]     best_idx_r;
  logic                 out_valid_r;
  logic                 out_found_r;
  logic [BIN_OUT_W-1:0] out_bin_r;
  logic [CNT_W-1:0]     out_peak_r;

  logic                 in_fire;
  logic                 last_bin;
  logic                 is_hit;
  logic [CNT_W-1:0]     cnt_new;
  logic                 take;
  logic                 load_go;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign last_bin = (idx_r == IDX_W'(NUM_BINS - 1));
  assign load_go  = (state_r == ST_LOAD) && (!out_valid_r || out_ch.ready);

  // Earlier bins missed, so the hit bin is the first one whose bound exceeds x, or the last bin
  assign is_hit = !hit_seen_r && (last_bin || (BOUND_W'(x_r) < bound_r));

  bbpt_bin_unit u_bin (
    .cfg      (cfg_r),
    .cnt_i    (counts_r[idx_r]),
    .hit_i    (is_hit),
    .radius_i (radius_r),
    .best_i   (best_r),
    .cnt_o    (cnt_new),
    .take_o   (take)
  );

  // Sequence accept, bin walk and result load
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (last_bin) state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (load_go) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_radius        <= MIN_RADIUS_RST;
      cfg_r.present_threshold <= PRESENT_THR_RST;
      cfg_r.count_ceiling     <= COUNT_CEILING_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIN_RADIUS:    cfg_r.min_radius        <= cfg_wdata[RAD_W-1:0];
        REG_PRESENT_THR:   cfg_r.present_threshold <= cfg_wdata[CNT_W-1:0];
        REG_COUNT_CEILING: cfg_r.count_ceiling     <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the word and reset the walk
  always_ff @(posedge clk) begin
    if (in_fire) begin
      x_r      <= in_ch.center_x;
      radius_r <= in_ch.radius;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r      <= '0;
      bound_r    <= '0;
      hit_seen_r <= 1'b0;
      best_r     <= '0;
      best_idx_r <= '0;
    end else if (in_fire) begin
      idx_r      <= '0;
      bound_r    <= BOUND_W'(BIN_WIDTH);
      hit_seen_r <= 1'b0;
      best_r     <= '0;
      best_idx_r <= '0;
    end else if (state_r == ST_WALK) begin
      // Advance one bin and track the running best
      idx_r   <= last_bin ? idx_r : (idx_r + IDX_W'(1));
      bound_r <= last_bin ? bound_r : (bound_r + BOUND_W'(BIN_WIDTH));
      if (is_hit) hit_seen_r <= 1'b1;
      if (take) begin
        best_r.found <= 1'b1;
        best_r.peak  <= cnt_new;
        best_idx_r   <= idx_r;
      end
    end
  end

  // Update bin counters, one per walk cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_BINS; i++) counts_r[i] <= '0;
    end else if (state_r == ST_WALK) begin
      counts_r[idx_r] <= cnt_new;
    end
  end

  // Hold the result word until the sink takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_go) begin
      out_found_r <= best_r.found;
      out_bin_r   <= best_r.found ? BIN_OUT_W'(best_idx_r) : '0;
      out_peak_r  <= best_r.found ? best_r.peak : '0;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.found      = out_found_r;
  assign out_ch.ball_bin   = out_bin_r;
  assign out_ch.peak_count = out_peak_r;

  // Every walk marks exactly one bin as hit before the load
  a_hit_each_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD && $past(state_r) == ST_WALK) |-> hit_seen_r)
    else $error("walk finished without a hit bin");

  // An accepted word starts the walk at the first bin
  a_walk_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_WALK && idx_r == '0))
    else $error("walk did not start at bin zero");

  // The walk index stays within the bins
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> (idx_r <= IDX_W'(NUM_BINS - 1)))
    else $error("bin index out of range");

  // A result without a qualifying bin reports zeros
  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.found) |-> (out_ch.ball_bin == '0 && out_ch.peak_count == '0))
    else $error("empty result carries bin or count");

endmodule

/* hdl/bbpt_bin_unit.sv */
// ----------------------------------------------------------------------------
// bbpt_bin_unit
// Shared per-bin unit: updates one bin counter and checks it against the
// running best of the search.
// ----------------------------------------------------------------------------
module bbpt_bin_unit (
  input  bbpt_pkg::bbpt_cfg_t          cfg,
  input  logic [bbpt_pkg::CNT_W-1:0]   cnt_i,
  input  logic                         hit_i,
  input  logic [bbpt_pkg::RAD_W-1:0]   radius_i,
  input  bbpt_pkg::bbpt_best_t         best_i,
  output logic [bbpt_pkg::CNT_W-1:0]   cnt_o,
  output logic                         take_o
);
  import bbpt_pkg::*;

  logic [CNT_W:0]   rise;
  logic [CNT_W-1:0] rise_sat;
  logic [CNT_W-1:0] fall;

  // Rise by the hit step with saturation, fall toward zero
  assign rise     = {1'b0, cnt_i} + (CNT_W + 1)'(HIT_STEP);
  assign rise_sat = (rise > (CNT_W + 1)'(CNT_MAX)) ? CNT_W'(CNT_MAX) : rise[CNT_W-1:0];
  assign fall     = (cnt_i != '0) ? (cnt_i - CNT_W'(1)) : cnt_i;

  // Pick the new counter value
  always_comb begin
    cnt_o = fall;
    if (hit_i) begin
      if (cnt_i < cfg.count_ceiling) begin
        cnt_o = (radius_i > cfg.min_radius) ? rise_sat : fall;
      end else begin
        cnt_o = cnt_i;
      end
    end
  end

  // Strictly greater keeps the lowest bin on a tie
  assign take_o = (cnt_o > cfg.present_threshold) && (!best_i.found || cnt_o > best_i.peak);

endmodule
